// ===== hw/rtl/acv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and letter arithmetic for the autokey Vigenere cipher.
// No dependencies.
package acv_pkg;

    localparam int KEY_MAX_DEF = 12;
    localparam int KLEN_W      = 4;
    localparam int LETTER_W    = 5;
    localparam int CHAR_W      = 8;
    localparam int KWORD_W     = 60;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KWORD_W;

    localparam logic [LETTER_W-1:0] LETTERS   = LETTER_W'(26);
    localparam logic [CHAR_W-1:0]   UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0]   LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0]   UPPER_END = UPPER_A + CHAR_W'(LETTERS);
    localparam logic [CHAR_W-1:0]   LOWER_END = LOWER_A + CHAR_W'(LETTERS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 2'd0,
        REG_KEY_LENGTH = 2'd1,
        REG_KEYWORD    = 2'd2
    } t_reg_idx;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [KLEN_W-1:0]   key_length;
        logic [KWORD_W-1:0]  keyword;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [CHAR_W-1:0]   out_char;
    } t_res;

    function automatic logic [LETTER_W-1:0] key_mod(input logic [LETTER_W-1:0] k);
        return (k >= LETTERS) ? (k - LETTERS) : k;
    endfunction

    function automatic logic [LETTER_W-1:0] shift_letter(
        input logic [LETTER_W-1:0] letter,
        input logic [LETTER_W-1:0] k,
        input t_mode               mode
    );
        logic [LETTER_W:0] sum;
        if (mode == MODE_ENCODE) begin
            sum = {1'b0, letter} + {1'b0, k};
        end else begin
            sum = {1'b0, letter} + {1'b0, LETTERS} - {1'b0, k};
        end
        if (sum >= {1'b0, LETTERS}) begin
            sum = sum - {1'b0, LETTERS};
        end
        return sum[LETTER_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/acv_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one source byte and its restart flag per beat.
// Depends on acv_pkg.
interface acv_in_if import acv_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              restart;

    modport source (output valid, output in_char, output restart, input ready);
    modport sink   (input valid, input in_char, input restart, output ready);
endinterface

// ===== hw/rtl/acv_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one transformed byte per beat.
// Depends on acv_pkg.
interface acv_out_if import acv_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;

    modport source (output valid, output out_char, input ready);
    modport sink   (input valid, input out_char, output ready);
endinterface

// ===== hw/rtl/acv_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data per beat.
// Depends on acv_pkg.
interface acv_cfg_if import acv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/acv_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers: mode, key length and keyword.
// Depends on acv_pkg and acv_cfg_if.
module acv_cfg_regs import acv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acv_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_ENCODE;
            r_cfg.key_length <= KLEN_W'(1);
            r_cfg.keyword    <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MODE:       r_cfg.mode       <= t_mode'(i_cfg.data[0]);
                REG_KEY_LENGTH: r_cfg.key_length <= i_cfg.data[KLEN_W-1:0];
                REG_KEYWORD:    r_cfg.keyword    <= i_cfg.data[KWORD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/acv_key_ring.sv =====
`timescale 1ns / 1ps
// Key ring memory with read-modify-write pipeline and letter transform.
// Depends on acv_pkg.
module acv_key_ring import acv_pkg::*; #(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_acc,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_restart,
    output t_res              o_res
);

    localparam int IW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [KLEN_W-1:0] KMAX_L = KLEN_W'(KEY_MAX);

    logic [LETTER_W-1:0] kw_arr [KEY_MAX];
    logic [LETTER_W-1:0] r_snap [KEY_MAX];
    logic                r_own  [KEY_MAX];
    logic [LETTER_W-1:0] r_ring [KEY_MAX];
    logic [LETTER_W-1:0] r_rdata;
    logic [IW-1:0]       r_pos;

    logic                is_upper;
    logic                is_lower;
    logic                is_letter;
    logic [CHAR_W-1:0]   offs;
    logic [KLEN_W-1:0]   eff;
    logic [IW-1:0]       pos_base;
    logic [IW-1:0]       pos;
    logic [KLEN_W-1:0]   pos_inc;
    logic [IW-1:0]       n_pos;
    logic                fwd;

    logic                r_s1_v;
    logic                r_s1_letter;
    logic                r_s1_lower;
    logic [CHAR_W-1:0]   r_s1_char;
    logic [LETTER_W-1:0] r_s1_lval;
    logic [IW-1:0]       r_s1_pos;
    logic                r_s1_fwd;
    logic                r_s1_own;
    logic [LETTER_W-1:0] r_s1_snap;
    logic [LETTER_W-1:0] r_fwd_plain;

    logic [LETTER_W-1:0] s1_key;
    logic [LETTER_W-1:0] s1_res;
    logic [LETTER_W-1:0] s1_plain;
    logic [CHAR_W-1:0]   s1_base;

    for (genvar g = 0; g < KEY_MAX; g++) begin : g_kw
        assign kw_arr[g] = i_cfg.keyword[g*LETTER_W +: LETTER_W];
    end

    // stage 0: classify, pick position, pick key source
    always_comb begin
        is_upper  = (i_char >= UPPER_A) && (i_char < UPPER_END);
        is_lower  = (i_char >= LOWER_A) && (i_char < LOWER_END);
        is_letter = is_upper || is_lower;
        offs      = i_char - (is_lower ? LOWER_A : UPPER_A);
        if (i_cfg.key_length == '0) begin
            eff = KLEN_W'(1);
        end else if (i_cfg.key_length > KMAX_L) begin
            eff = KMAX_L;
        end else begin
            eff = i_cfg.key_length;
        end
        pos_base = i_restart ? '0 : r_pos;
        pos      = (KLEN_W'(pos_base) >= eff) ? '0 : pos_base;
        pos_inc  = KLEN_W'(pos) + KLEN_W'(1);
        n_pos    = (pos_inc >= eff) ? '0 : pos_inc[IW-1:0];
        fwd      = r_s1_v && r_s1_letter && (r_s1_pos == pos) && !i_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int i = 0; i < KEY_MAX; i++) begin
                r_own[i]  <= 1'b0;
                r_snap[i] <= '0;
            end
        end else if (i_acc) begin
            r_pos <= is_letter ? n_pos : pos_base;
            for (int i = 0; i < KEY_MAX; i++) begin
                if (i_restart || (is_letter && (pos == IW'(i)))) begin
                    r_own[i] <= is_letter && (pos == IW'(i));
                end
            end
            if (i_restart) begin
                for (int i = 0; i < KEY_MAX; i++) begin
                    r_snap[i] <= kw_arr[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && r_s1_letter) begin
            r_ring[r_s1_pos] <= s1_plain;
        end
        r_rdata <= r_ring[pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_plain <= s1_plain;
        if (i_acc) begin
            r_s1_letter <= is_letter;
            r_s1_lower  <= is_lower;
            r_s1_char   <= i_char;
            r_s1_lval   <= offs[LETTER_W-1:0];
            r_s1_pos    <= pos;
            r_s1_fwd    <= fwd;
            r_s1_own    <= i_restart ? 1'b0 : r_own[pos];
            r_s1_snap   <= i_restart ? kw_arr[pos] : r_snap[pos];
        end
    end

    // stage 1: resolve key, transform, write back
    always_comb begin
        if (r_s1_fwd) begin
            s1_key = r_fwd_plain;
        end else if (r_s1_own) begin
            s1_key = r_rdata;
        end else begin
            s1_key = r_s1_snap;
        end
        s1_res   = shift_letter(r_s1_lval, key_mod(s1_key), i_cfg.mode);
        s1_plain = (i_cfg.mode == MODE_ENCODE) ? r_s1_lval : s1_res;
        s1_base  = r_s1_lower ? LOWER_A : UPPER_A;
    end

    assign o_res.valid    = r_s1_v;
    assign o_res.out_char = r_s1_letter ? (s1_base + CHAR_W'(s1_res)) : r_s1_char;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) < KEY_MAX)
        else $error("ring position out of range");

    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_fwd |->
            $past(r_s1_v) && $past(r_s1_letter) && ($past(r_s1_pos) == r_s1_pos))
        else $error("forward without matching write");

    a_fwd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_restart |=> !r_s1_fwd && !r_s1_own)
        else $error("restart beat took key from ring");
`endif

endmodule

// ===== hw/rtl/acv_out_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry output buffer that decouples the pipeline from receiver stalls.
// Depends on acv_pkg and acv_out_if.
module acv_out_fifo import acv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res        i_push,
    acv_out_if.source   o_out,
    output logic [1:0]  o_cnt
);

    logic [CHAR_W-1:0] r_buf [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              pop;

    assign pop          = o_out.valid && o_out.ready;
    assign o_out.valid  = (r_cnt != 2'd0);
    assign o_out.out_char = r_buf[r_rp];
    assign o_cnt        = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_buf[r_wp] <= i_push.out_char;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !pop |-> !i_push.valid)
        else $error("push into full buffer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("buffer count corrupt");
`endif

endmodule

// ===== hw/rtl/autokey_vigenere_cipher.sv =====
`timescale 1ns / 1ps
// Autokey Vigenere byte cipher, top level.
// Depends on acv_pkg, acv_in_if, acv_out_if, acv_cfg_if, acv_cfg_regs,
// acv_key_ring and acv_out_fifo.
//
// Usage:
//   i_cfg  : write beats set mode (index 0), key length (index 1) and the
//            keyword letters (index 2); always ready. Write only while idle.
//   i_src  : one byte per beat with a restart flag that reloads the key ring
//            from the keyword before that byte.
//   o_res  : one transformed byte per accepted input byte, in order.
// Path: an accepted byte is registered in the key ring's stage 1, then
//   written into the output buffer, which presents it on o_res.
// Throughput: one byte per cycle unless i_src.ready drops; the key ring
//   is a registered-read memory; back-to-back same-entry hits are forwarded.
// Reset: synchronous, active low; the key ring reads as all letter A, the
//   ring position is zero, mode encode, key length 1, keyword zero. No
//   clearing pass is needed.
// Stalls: a two-entry output buffer absorbs the byte in flight; i_src.ready
//   drops while buffer and pipeline stage hold two bytes and none leaves.
module autokey_vigenere_cipher import acv_pkg::*; #(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acv_cfg_if.sink    i_cfg,
    acv_in_if.sink     i_src,
    acv_out_if.source  o_res
);

    t_cfg       cfg;
    t_res       s1_res;
    logic [1:0] fifo_cnt;
    logic       acc;
    logic       pop;
    logic [2:0] load;

    assign pop         = o_res.valid && o_res.ready;
    assign load        = 3'(fifo_cnt) + 3'(s1_res.valid);
    assign i_src.ready = (load <= (3'd1 + 3'(pop)));
    assign acc         = i_src.valid && i_src.ready;

    acv_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    acv_key_ring #(
        .KEY_MAX (KEY_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_acc     (acc),
        .i_char    (i_src.in_char),
        .i_restart (i_src.restart),
        .o_res     (s1_res)
    );

    acv_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_res),
        .o_out   (o_res),
        .o_cnt   (fifo_cnt)
    );

endmodule
